[sv/srs_pkg.sv]
// Package for the streaming search and replace block: sizes, types and register codes.
`default_nettype none
package srs_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int RES_MAX     = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int HELD_W      = $clog2(PATTERN_MAX);
  localparam int CNT_W       = $clog2(RES_MAX + 1);
  localparam int LEN_W       = 4;
  localparam int CFG_W       = 64;

  typedef logic [7:0] byte_t;
  typedef logic [PATTERN_MAX-1:0][7:0] pat_vec_t;
  typedef logic [RES_MAX-1:0][7:0] res_vec_t;

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_t;

endpackage
`default_nettype wire

[sv/srs_stream_if.sv]
// Stream interfaces for the input and result channels of the search and replace block.
`default_nettype none
interface srs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface srs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_empty;
  logic       out_last;

  modport source (output valid, output out_byte, output out_empty, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_empty, input out_last, output ready);
endinterface
`default_nettype wire

[sv/substring_replace_stream_core.sv]
// Streaming search and replace: each input word is registered, matched against the
// configured pattern in combinational logic and its results are loaded into a result
// buffer that drains one word per cycle while the output is ready. A word that yields
// one result (or none) does not stall the input, so plain text flows at one word per
// cycle while the output is ready. A word that yields several results (a completed match,
// bytes released when a partial match fails, or the held tail flushed at the end of a
// string) holds the output until all its words (up to eight) drain, and the input side
// stalls until the last of them is popped. The result buffer is the only shared resource
// that sets the rate. Configuration must be written only while idle; the block does not
// enforce this. A write of the pattern or its length drops any partly matched bytes.
`default_nettype none
module substring_replace_stream_core import srs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  srs_in_if.sink                in_chan,
  srs_out_if.source             out_chan,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  // Configuration registers
  pat_vec_t         pat_r;
  logic [LEN_W-1:0] plen_r;
  res_vec_t         rep_r;
  logic [LEN_W-1:0] rlen_r;

  // Input register
  logic             in_valid_r;
  byte_t            in_byte_r;
  logic             in_last_r;

  // Partial match state
  pat_vec_t          held_r;
  logic [HELD_W-1:0] held_cnt_r;

  // Result buffer, entry 0 is on the output
  res_vec_t         res_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic             res_last_r;
  logic             res_empty_r;

  logic              xfer;
  logic              pop;
  logic [LEN_W-1:0]  plen_eff;
  logic [LEN_W-1:0]  rlen_eff;
  logic [LEN_W-1:0]  plen_m1;
  logic [HELD_W-1:0] h;
  logic [CNT_W-1:0]  cnt;
  pat_vec_t          buf_b;
  logic [PATTERN_MAX-1:0] ok;
  logic [CNT_W-1:0]  s_sel;
  logic [CNT_W-1:0]  idx;
  logic              full;
  pat_vec_t          held_nxt;
  logic [HELD_W-1:0] held_cnt_nxt;
  res_vec_t          res_nxt;
  logic [CNT_W-1:0]  res_cnt_nxt;
  logic              res_empty_nxt;
  cfg_idx_t          cfg_sel;

  assign pop  = out_chan.valid && out_chan.ready;
  // A new word moves into the result buffer once the buffer is empty or losing its last entry
  assign xfer = in_valid_r && ((res_cnt_r == '0) || (res_cnt_r == CNT_W'(1) && out_chan.ready));

  assign in_chan.ready      = !in_valid_r || xfer;
  assign out_chan.valid     = (res_cnt_r != '0);
  assign out_chan.out_byte  = res_r[0];
  assign out_chan.out_empty = res_empty_r;
  assign out_chan.out_last  = res_last_r && (res_cnt_r == CNT_W'(1));

  assign cfg_sel = cfg_idx_t'(cfg_index);

  always_comb begin
    plen_eff = (plen_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : plen_r;
    rlen_eff = (rlen_r > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rlen_r;
    plen_m1  = plen_eff - LEN_W'(1);
    h   = ({1'b0, held_cnt_r} > plen_m1) ? plen_m1[HELD_W-1:0] : held_cnt_r;
    cnt = CNT_W'(h) + CNT_W'(1);

    // Held bytes followed by the incoming byte
    for (int i = 0; i < PATTERN_MAX; i++) begin
      buf_b[i] = (HELD_W'(i) < h) ? held_r[i] : in_byte_r;
    end

    // ok[s]: the bytes from position s to the end form a prefix of the pattern
    for (int s = 0; s < PATTERN_MAX; s++) begin
      ok[s] = (CNT_W'(s) < cnt);
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (s + i < PATTERN_MAX) begin
          if ((CNT_W'(s + i) < cnt) && (buf_b[s + i] != pat_r[i])) begin
            ok[s] = 1'b0;
          end
        end
      end
    end

    s_sel = cnt;
    for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
      if (ok[s]) begin
        s_sel = CNT_W'(s);
      end
    end
    full = ok[0] && (cnt == CNT_W'(plen_eff));

    for (int k = 0; k < PATTERN_MAX; k++) begin
      idx = s_sel + CNT_W'(k);
      held_nxt[k] = buf_b[idx[HELD_W-1:0]];
    end
    held_cnt_nxt = HELD_W'(cnt - s_sel);

    res_nxt       = '0;
    res_cnt_nxt   = '0;
    res_empty_nxt = 1'b0;
    if (plen_eff == '0) begin
      res_nxt[0]   = in_byte_r;
      res_cnt_nxt  = CNT_W'(1);
      held_cnt_nxt = '0;
    end else if (full) begin
      res_nxt      = rep_r;
      res_cnt_nxt  = CNT_W'(rlen_eff);
      held_cnt_nxt = '0;
    end else begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        res_nxt[i] = buf_b[i];
      end
      // On the last word the held tail is flushed behind the released bytes
      res_cnt_nxt = in_last_r ? cnt : s_sel;
    end

    if (in_last_r) begin
      held_cnt_nxt = '0;
      if (res_cnt_nxt == '0) begin
        res_nxt       = '0;
        res_cnt_nxt   = CNT_W'(1);
        res_empty_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      held_cnt_r  <= '0;
      res_cnt_r   <= '0;
      res_last_r  <= 1'b0;
      res_empty_r <= 1'b0;
      pat_r       <= '0;
      plen_r      <= '0;
      rep_r       <= '0;
      rlen_r      <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        in_valid_r <= 1'b1;
        in_byte_r  <= in_chan.in_byte;
        in_last_r  <= in_chan.is_last;
      end else if (xfer) begin
        in_valid_r <= 1'b0;
      end

      if (xfer) begin
        res_r       <= res_nxt;
        res_cnt_r   <= res_cnt_nxt;
        res_last_r  <= in_last_r;
        res_empty_r <= res_empty_nxt;
        held_r      <= held_nxt;
        held_cnt_r  <= held_cnt_nxt;
      end else if (pop) begin
        res_r     <= res_r >> 8;
        res_cnt_r <= res_cnt_r - CNT_W'(1);
      end

      if (cfg_we) begin
        unique case (cfg_sel)
          CFG_PATTERN_BYTES: begin
            pat_r      <= cfg_wdata;
            held_cnt_r <= '0;
          end
          CFG_PATTERN_LENGTH: begin
            plen_r     <= cfg_wdata[LEN_W-1:0];
            held_cnt_r <= '0;
          end
          CFG_REPLACEMENT_BYTES: begin
            rep_r <= cfg_wdata;
          end
          CFG_REPLACEMENT_LENGTH: begin
            rlen_r <= cfg_wdata[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // An empty result only ever closes a string
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.out_empty) |-> out_chan.out_last)
    else $error("empty result without end mark");

  // Fewer bytes are held than the pattern is long
  a_held_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (held_cnt_r == '0) || (CNT_W'(held_cnt_r) < CNT_W'(plen_eff)))
    else $error("held count not below pattern length");

  // With an empty result buffer the input side never stalls
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt_r == '0) |-> in_chan.ready)
    else $error("input stalled with empty result buffer");

  // A word taken into the buffer leaves the input register free unless refilled
  a_xfer_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !in_chan.valid) |=> !in_valid_r)
    else $error("input register not released after transfer");
`endif

endmodule
`default_nettype wire
